// File: sv/fvnh_pkg.sv
// Shared types and constants for the fractal value-noise height generator.
package fvnh_pkg;

  // Fraction bits of the coordinate format.
  localparam int FRAC_BITS = 16;

  // Width of a frequency-scaled coordinate.
  localparam int SX_W = 40;

  // Configuration register indexes.
  localparam logic [2:0] REG_PERSISTENCE = 3'd0;
  localparam logic [2:0] REG_BASE_FREQ   = 3'd1;
  localparam logic [2:0] REG_AMPLITUDE   = 3'd2;
  localparam logic [2:0] REG_OCTAVES     = 3'd3;
  localparam logic [2:0] REG_SEED        = 3'd4;

  // Octave weight of the first octave (1.0 in Q16) and its ceiling.
  localparam logic [32:0] W_ONE = 33'd65536;
  localparam logic [32:0] W_MAX = 33'h1_0000_0000;

  // One item as it travels from octave cell to octave cell.
  typedef struct packed {
    logic                   valid;
    logic signed [SX_W-1:0] sx;
    logic signed [SX_W-1:0] sy;
    logic signed [63:0]     total;
  } pkt_t;

  // Configuration seen by every octave cell.
  typedef struct packed {
    logic [17:0] persistence;
    logic [3:0]  octave_count;
    logic [29:0] seed_offset;
  } cfg_t;

endpackage

// File: sv/fractal_value_noise_height.sv
// Fractal value-noise height generator, top level.
// Takes one coordinate pair per cycle unless the pipeline halts, and returns one
// height per item, in order. The item passes a scaling stage, a chain of
// MAX_OCTAVES octave cells of 14 stages each, three output scaling stages and
// the output register, whatever the octave count; octaves beyond the count pass
// through without adding. The whole pipeline halts only while a result waits in
// the output register and another is ready behind it. Configuration applies to
// items accepted after the write; a write while items are in flight may alter
// their results.
module fractal_value_noise_height #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // coord_x [31:0], coord_y [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // height [31:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fvnh_pkg::*;

  cfg_t               cfg;
  logic [31:0]        base_frequency;
  logic signed [31:0] amplitude;
  logic               en, res_valid;
  logic [31:0]        res_height;
  logic signed [64:0] px, py;
  pkt_t               pkt [MAX_OCTAVES+1];
  logic [32:0]        wt [MAX_OCTAVES+1];

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg            <= '0;
      base_frequency <= '0;
      amplitude      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PERSISTENCE: cfg.persistence  <= cfg_data[17:0];
        REG_BASE_FREQ:   base_frequency   <= cfg_data;
        REG_AMPLITUDE:   amplitude        <= $signed(cfg_data);
        REG_OCTAVES:     cfg.octave_count <= cfg_data[3:0];
        REG_SEED:        cfg.seed_offset  <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances unless a waiting result would be overwritten.
  assign en       = !(res_valid && m_tvalid && !m_tready);
  assign s_tready = en;

  // Frequency scaling of both coordinates, floored to the coordinate format.
  assign px = 65'($signed(s_tdata[31:0])) * 65'($signed({1'b0, base_frequency}));
  assign py = 65'($signed(s_tdata[63:32])) * 65'($signed({1'b0, base_frequency}));

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt[0].valid <= 1'b0;
    end else if (en) begin
      pkt[0].valid <= s_tvalid;
      pkt[0].sx    <= px[63:24];
      pkt[0].sy    <= py[63:24];
      pkt[0].total <= '0;
    end
  end

  // Chain of octave cells.
  assign wt[0] = W_ONE;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    fvnh_cell #(.K(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .cfg     (cfg),
      .pkt_in  (pkt[k]),
      .w_in    (wt[k]),
      .pkt_out (pkt[k+1]),
      .w_out   (wt[k+1])
    );
  end

  fvnh_out u_out (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .pkt_in     (pkt[MAX_OCTAVES]),
    .amplitude  (amplitude),
    .res_valid  (res_valid),
    .res_height (res_height)
  );

  // Output register; a transaction completes on tvalid and tready.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && en) begin
      m_tvalid <= 1'b1;
      m_tdata  <= res_height;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// File: sv/fvnh_lat.sv
// Lattice value pipeline: integer hash of one lattice point, five stages.
module fvnh_lat (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        n_in,
  output logic signed [31:0] g
);
  import fvnh_pkg::*;

  logic [31:0] n1, n2, n3, m1, inner, sum4;
  logic [30:0] t;

  assign sum4 = n3 * inner + 32'd1376312589;

  // Shift-xor mix, squaring, polynomial and final mask, one multiply a stage.
  always_ff @(posedge clk) begin
    if (en) begin
      n1    <= n_in ^ (n_in << 13);
      m1    <= n1 * n1;
      n2    <= n1;
      inner <= m1 * 32'd15731 + 32'd789221;
      n3    <= n2;
      t     <= sum4[30:0];
      g     <= 32'sd1073741824 - $signed({1'b0, t});
    end
  end

endmodule

// File: sv/fvnh_cell.sv
// Octave cell: one octave of smoothed value noise, added to the running total.
module fvnh_cell #(
  parameter int K = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  fvnh_pkg::cfg_t cfg,
  input  fvnh_pkg::pkt_t pkt_in,
  input  logic [32:0]    w_in,
  output fvnh_pkg::pkt_t pkt_out,
  output logic [32:0]    w_out
);
  import fvnh_pkg::*;

  localparam int LAT  = 14;
  localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

  typedef struct packed {
    logic signed [19:0] f1a;
    logic signed [19:0] f2a;
    logic signed [19:0] f1b;
    logic signed [19:0] f2b;
  } ease_t;

  pkt_t line [LAT];

  logic [63:0] ua, ub, maga, magb, ipma, ipmb;
  logic        nega, negb;
  logic [15:0] f16a, f16b;
  logic [31:0] idxa, idxb, base;
  logic signed [16:0] aa, ab, aa4, ab4;
  logic [31:0] a2a, a2b, a2a5, a2b5;
  logic signed [49:0] pa, pb;
  logic signed [52:0] ea, eb;
  logic signed [19:0] f2a6, f2b6;
  ease_t ez [5];
  logic signed [31:0] g [16];
  logic signed [35:0] c00, c01, c10, c11;
  logic signed [56:0] p0, p1;
  logic signed [61:0] q;
  logic signed [63:0] prod, prod_add;
  logic [50:0] wp;
  logic active;

  // Octave enabled by the octave count.
  assign active = {1'b0, cfg.octave_count} > 5'(K);

  // Split of both axes into lattice index and signed 16-bit fraction.
  always_comb begin
    ipma = maga >> FRAC_BITS;
    ipmb = magb >> FRAC_BITS;
    f16a = 16'(((maga & FRAC_MASK) >> SH_R) << SH_L);
    f16b = 16'(((magb & FRAC_MASK) >> SH_R) << SH_L);
  end

  // Smoothstep numerator: 3a^2 * 2^16 - 2a^3, floored by 2^32 afterwards.
  always_comb begin
    ea = ((53'($signed({1'b0, a2a5})) <<< 16) * 53'sd3) - (53'(pa) <<< 1);
    eb = ((53'($signed({1'b0, a2b5})) <<< 16) * 53'sd3) - (53'(pb) <<< 1);
  end

  // Coordinate, fraction and ease pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      ua   <= (64'(pkt_in.sy) << K) + (64'(cfg.seed_offset) << FRAC_BITS);
      ub   <= (64'(pkt_in.sx) << K) + (64'(cfg.seed_offset) << FRAC_BITS);
      nega <= ua[63];
      negb <= ub[63];
      maga <= ua[63] ? -ua : ua;
      magb <= ub[63] ? -ub : ub;
      idxa <= nega ? 32'(-ipma) : ipma[31:0];
      idxb <= negb ? 32'(-ipmb) : ipmb[31:0];
      aa   <= nega ? -$signed({1'b0, f16a}) : $signed({1'b0, f16a});
      ab   <= negb ? -$signed({1'b0, f16b}) : $signed({1'b0, f16b});
      base <= idxa + idxb * 32'd57;
      a2a  <= 32'(34'(aa) * 34'(aa));
      a2b  <= 32'(34'(ab) * 34'(ab));
      aa4  <= aa;
      ab4  <= ab;
      pa   <= 50'(aa4) * 50'($signed({1'b0, a2a}));
      pb   <= 50'(ab4) * 50'($signed({1'b0, a2b}));
      a2a5 <= a2a;
      a2b5 <= a2b;
      f2a6 <= ea[51:32];
      f2b6 <= eb[51:32];
      ez[0] <= '{f1a: 20'sd65536 - f2a6, f2a: f2a6, f1b: 20'sd65536 - f2b6, f2b: f2b6};
      for (int i = 1; i < 5; i++) begin
        ez[i] <= ez[i-1];
      end
    end
  end

  // Sixteen lattice points around the cell, one hash lane each.
  for (genvar j = 0; j < 4; j++) begin : g_row
    for (genvar i = 0; i < 4; i++) begin : g_col
      fvnh_lat u_lat (
        .clk  (clk),
        .en   (en),
        .n_in (base + 32'(i + 57 * j - 58)),
        .g    (g[j*4+i])
      );
    end
  end

  // Smoothing, the two blends and the octave weighting.
  always_ff @(posedge clk) begin
    if (en) begin
      c00 <= 36'(g[0]) + 36'(g[2]) + 36'(g[8]) + 36'(g[10])
           + ((36'(g[1]) + 36'(g[9]) + 36'(g[4]) + 36'(g[6])) <<< 1)
           + (36'(g[5]) <<< 2);
      c01 <= 36'(g[1]) + 36'(g[3]) + 36'(g[9]) + 36'(g[11])
           + ((36'(g[2]) + 36'(g[10]) + 36'(g[5]) + 36'(g[7])) <<< 1)
           + (36'(g[6]) <<< 2);
      c10 <= 36'(g[4]) + 36'(g[6]) + 36'(g[12]) + 36'(g[14])
           + ((36'(g[5]) + 36'(g[13]) + 36'(g[8]) + 36'(g[10])) <<< 1)
           + (36'(g[9]) <<< 2);
      c11 <= 36'(g[5]) + 36'(g[7]) + 36'(g[13]) + 36'(g[15])
           + ((36'(g[6]) + 36'(g[14]) + 36'(g[9]) + 36'(g[11])) <<< 1)
           + (36'(g[10]) <<< 2);
      p0   <= 57'(c00) * 57'(ez[3].f1a) + 57'(c01) * 57'(ez[3].f2a);
      p1   <= 57'(c10) * 57'(ez[3].f1a) + 57'(c11) * 57'(ez[3].f2a);
      q    <= 62'($signed(p0[56:16])) * 62'(ez[4].f1b)
            + 62'($signed(p1[56:16])) * 62'(ez[4].f2b);
      prod <= 64'($signed(q[61:34])) * 64'($signed({1'b0, w_in}));
    end
  end

  assign prod_add = active ? prod : 64'sd0;

  // Item delay line; the last stage adds this octave to the total.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        line[i].valid <= 1'b0;
      end
    end else if (en) begin
      line[0] <= pkt_in;
      for (int i = 1; i < LAT - 1; i++) begin
        line[i] <= line[i-1];
      end
      line[LAT-1] <= '{valid: line[LAT-2].valid, sx: line[LAT-2].sx, sy: line[LAT-2].sy,
                       total: line[LAT-2].total + prod_add};
    end
  end

  assign pkt_out = line[LAT-1];

  // Weight of the next octave, saturated at 65536.0.
  assign wp = 51'(w_in) * 51'(cfg.persistence);

  always_ff @(posedge clk) begin
    w_out <= (wp[50:16] > 35'(W_MAX)) ? W_MAX : wp[48:16];
  end

endmodule

// File: sv/fvnh_out.sv
// Output scaling: total times amplitude, truncated toward zero and saturated.
module fvnh_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  fvnh_pkg::pkt_t     pkt_in,
  input  logic signed [31:0] amplitude,
  output logic               res_valid,
  output logic [31:0]        res_height
);
  import fvnh_pkg::*;

  logic signed [47:0] t16;
  logic [47:0] tmag;
  logic [31:0] amag;
  logic        neg1, neg2, v1, v2;
  logic [55:0] phi, plo;
  logic [40:0] rmag;

  assign t16 = pkt_in.total[63:16];

  // Magnitude product rebuilt from two partial products.
  assign rmag = (phi >= 56'h1_0000_0000) ? 41'h1_0000_0000
              : 41'(phi << 8) + 41'(plo >> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      tmag <= t16[47] ? 48'(-t16) : 48'(t16);
      amag <= amplitude[31] ? 32'(-amplitude) : 32'(amplitude);
      neg1 <= t16[47] ^ amplitude[31];
      phi  <= 56'(tmag[47:24]) * 56'(amag);
      plo  <= 56'(tmag[23:0]) * 56'(amag);
      neg2 <= neg1;
      if (neg2) begin
        res_height <= (rmag > 41'h0_8000_0000) ? 32'h8000_0000 : 32'(-rmag);
      end else begin
        res_height <= (rmag > 41'h0_7fff_ffff) ? 32'h7fff_ffff : rmag[31:0];
      end
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= pkt_in.valid;
      v2        <= v1;
      res_valid <= v2;
    end
  end

endmodule

// File: verif/fvnh_checker.sv
// Checker for the fractal value-noise height generator: tracks the registers, predicts and compares.
module fvnh_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          items_seen,
  output int          heights_seen
);
  import fvnh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OCTAVE_CAP = 8;

  typedef struct {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] height;
  } height_exp_t;

  // Register copies as the block should hold them.
  logic [17:0] persistence_q;
  logic [31:0] base_freq_q;
  logic [31:0] amplitude_q;
  logic [3:0]  octaves_q;
  logic [29:0] seed_q;

  height_exp_t heights_due[$];

  // Hashed lattice value in Q.30; all hash arithmetic wraps at 32 bits.
  function automatic longint lattice_value(logic [31:0] x, logic [31:0] y);
    logic [31:0] n, inner, t;
    n = x + y * 32'd57;
    n = (n << 13) ^ n;
    inner = n * n * 32'd15731 + 32'd789221;
    t = (n * inner + 32'd1376312589) & 32'h7fff_ffff;
    return longint'(1073741824) - longint'({32'b0, t});
  endfunction

  // Scales one coordinate for octave k and splits it into lattice index and signed fraction.
  function automatic void split_coord(input logic [31:0] coord, input int k,
                                      output logic [31:0] idx, output longint frac);
    longint      c, s;
    logic [63:0] u, mag, ipm;
    c = longint'(signed'(coord));
    s = (c * longint'({32'b0, base_freq_q})) >>> 24;
    u = (64'(s) << k) + ({34'b0, seed_q} << FRAC_BITS);
    mag = u[63] ? -u : u;
    ipm = mag >> FRAC_BITS;
    idx = u[63] ? 32'(-ipm) : ipm[31:0];
    frac = u[63] ? -longint'({48'b0, mag[15:0]}) : longint'({48'b0, mag[15:0]});
  endfunction

  // Cubic ease 3a^2 - 2a^3 in Q16.
  function automatic longint ease_q16(longint a);
    longint a2;
    a2 = a * a;
    return (3 * a2 * 65536 - 2 * a2 * a) >>> 32;
  endfunction

  function automatic longint mix(longint c0, longint c1, longint a);
    longint f2;
    f2 = ease_q16(a);
    return (c0 * (65536 - f2) + c1 * f2) >>> 16;
  endfunction

  // Smoothed, blended value of one octave.
  function automatic longint octave_sample(logic [31:0] cx, logic [31:0] cy, int k);
    logic [31:0] xi, yi;
    longint      xf, yf;
    longint      g [4][4];
    longint      c [2][2];
    split_coord(cy, k, xi, xf);
    split_coord(cx, k, yi, yf);
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++)
        g[j][i] = lattice_value(xi + 32'(i) - 32'd1, yi + 32'(j) - 32'd1);
    for (int j = 0; j < 2; j++)
      for (int i = 0; i < 2; i++)
        c[j][i] = g[j][i] + g[j][i+2] + g[j+2][i] + g[j+2][i+2]
                + 2 * (g[j][i+1] + g[j+2][i+1] + g[j+1][i] + g[j+1][i+2])
                + 4 * g[j+1][i+1];
    return mix(mix(c[0][0], c[0][1], xf), mix(c[1][0], c[1][1], xf), yf);
  endfunction

  // Full height of one coordinate pair under the current registers.
  function automatic logic [31:0] height_of(logic [31:0] cx, logic [31:0] cy);
    int          n;
    logic [63:0] w, tmag, amag, phi, plo, rmag;
    longint      total, t16, amp;
    logic        neg;
    n = (octaves_q > OCTAVE_CAP) ? OCTAVE_CAP : int'(octaves_q);
    w = 64'd65536;
    total = 0;
    for (int k = 0; k < n; k++) begin
      total += (octave_sample(cx, cy, k) >>> 18) * longint'(w);
      w = (w * {46'b0, persistence_q}) >> 16;
      if (w > 64'h1_0000_0000) w = 64'h1_0000_0000;
    end
    t16 = total >>> 16;
    amp = longint'(signed'(amplitude_q));
    neg = (t16 < 0) != (amp < 0);
    tmag = (t16 < 0) ? 64'(-t16) : 64'(t16);
    amag = (amp < 0) ? 64'(-amp) : 64'(amp);
    phi = (tmag >> 24) * amag;
    plo = (tmag & 64'hff_ffff) * amag;
    rmag = (phi >= 64'h1_0000_0000) ? 64'h1_0000_0000 : (phi << 8) + (plo >> 16);
    if (neg) return (rmag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-rmag);
    return (rmag > 64'h7fff_ffff) ? 32'h7fff_ffff : rmag[31:0];
  endfunction

  always @(posedge clk) begin
    height_exp_t e;
    if (rst) begin
      persistence_q <= '0;
      base_freq_q   <= '0;
      amplitude_q   <= '0;
      octaves_q     <= '0;
      seed_q        <= '0;
      errors        <= 0;
      items_seen    <= 0;
      heights_seen  <= 0;
      heights_due.delete();
    end else begin
      // Register writes; unknown indexes are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PERSISTENCE: persistence_q <= cfg_data[17:0];
          REG_BASE_FREQ:   base_freq_q   <= cfg_data;
          REG_AMPLITUDE:   amplitude_q   <= cfg_data;
          REG_OCTAVES:     octaves_q     <= cfg_data[3:0];
          REG_SEED:        seed_q        <= cfg_data[29:0];
          default: ;
        endcase
      end
      // Each accepted coordinate transaction queues its predicted height.
      if (s_tvalid && s_tready) begin
        e.cx = s_tdata[31:0];
        e.cy = s_tdata[63:32];
        e.height = height_of(e.cx, e.cy);
        heights_due.push_back(e);
        items_seen <= items_seen + 1;
      end
      // Each result transaction is compared with the oldest prediction.
      if (m_tvalid && m_tready) begin
        heights_seen <= heights_seen + 1;
        if (heights_due.size() == 0) begin
          $display("%0t: unexpected height %h with no prediction waiting", $time, m_tdata);
          errors <= errors + 1;
        end else begin
          e = heights_due.pop_front();
          if (m_tdata !== e.height) begin
            $display("%0t: height mismatch for x=%h y=%h: expected %h, actual %h",
                     $time, e.cx, e.cy, e.height, m_tdata);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= heights_due.size();
  end

endmodule

// File: verif/tb_fractal_value_noise_height.sv
// Testbench top for the fractal value-noise height generator: stimulus, stalls and verdict.
module tb_fractal_value_noise_height;
  import fvnh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int DRAIN_WAIT  = 130;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;    // coord_x [31:0], coord_y [63:32]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // height [31:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int errors, pending, items_seen, heights_seen;
  int rx_pct = 0;
  logic hold_req = 1'b0;
  logic hold_used;
  int hold_left;
  int idle_cycles;
  int tx_pct;

  always #5 clk = ~clk;

  fractal_value_noise_height DUT (.*);

  fvnh_checker checker_i (.*);

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_pct);
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send_coord(input logic [31:0] cx, input logic [31:0] cy);
    logic r;
    while ($urandom_range(99) < tx_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {cy, cx};
    do begin
      @(negedge clk);
      r = s_tready;
      @(posedge clk);
    end while (!r);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    logic r;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
    end while (!r);
  endtask

  // Mix of full-range values and small magnitudes around the origin.
  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    if ($urandom_range(1)) return $urandom;
    v = $urandom_range(0, 32'h0040_0000);
    return $urandom_range(1) ? -v : v;
  endfunction

  initial begin
    logic [31:0] pers, freq, amp, octs, seed;
    logic [31:0] edge_vals [6];
    edge_vals = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0001_0000,
                  32'hfffe_8000};
    tx_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // Register settings: saturating extremes, all zero, opposite extremes, then random.
      case (p)
        0: begin pers = 32'h3ffff; freq = 32'h0100_0000; amp = 32'h7fff_ffff;
                 octs = 15; seed = 0; end
        1: begin pers = 0; freq = 0; amp = 0; octs = 0; seed = 0; end
        2: begin pers = 32'h08000; freq = 32'hffff_ffff; amp = 32'h8000_0000;
                 octs = 8; seed = 32'h3fff_ffff; end
        default: begin
          pers = $urandom_range(1) ? $urandom_range(0, 32'h3ffff) : $urandom_range(0, 32'h10000);
          freq = $urandom_range(1) ? $urandom : $urandom_range(0, 32'h0400_0000);
          amp  = $urandom;
          octs = $urandom_range(0, 15);
          seed = $urandom_range(0, 32'h3fff_ffff);
        end
      endcase
      write_reg(REG_PERSISTENCE, pers);
      write_reg(REG_BASE_FREQ, freq);
      write_reg(REG_AMPLITUDE, amp);
      write_reg(REG_OCTAVES, octs);
      write_reg(REG_SEED, seed);
      write_reg(3'($urandom_range(5, 7)), $urandom);
      cfg_valid <= 1'b0;
      repeat (16) @(posedge clk);

      // Idling pattern rotates through none, sender, receiver and both.
      case (p % 4)
        0: begin tx_pct = 0;  rx_pct <= 0;  end
        1: begin tx_pct = 61; rx_pct <= 0;  end
        2: begin tx_pct = 0;  rx_pct <= 61; end
        default: begin tx_pct = 35; rx_pct <= 35; end
      endcase
      if (p == 4) hold_req <= 1'b1;

      // Corner coordinates first in the first phases.
      if (p < 3)
        for (int i = 0; i < 6; i++)
          for (int j = 0; j < 6; j += 2 + (p % 2))
            send_coord(edge_vals[i], edge_vals[(i + j) % 6]);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_coord(rand_coord(), rand_coord());
      s_tvalid <= 1'b0;

      // Drain before touching the registers again.
      wait (pending == 0);
      repeat (DRAIN_WAIT) @(posedge clk);
    end

    $display("Covered %0d coordinate pairs and %0d heights over %0d register settings,",
             items_seen, heights_seen, PHASES);
    $display("with extreme registers, corner coordinates, random stalls and a long hold-off.");
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
sv/fvnh_pkg.sv
sv/fvnh_lat.sv
sv/fvnh_cell.sv
sv/fvnh_out.sv
sv/fractal_value_noise_height.sv
verif/fvnh_checker.sv
verif/tb_fractal_value_noise_height.sv
